// ===== design/swd_pkg.sv =====
// Shared types and constants for the sliding-window 1-D DBSCAN labeler.
`default_nettype none
package swd_pkg;

    localparam int SWD_WINDOW_DEPTH = 64;
    localparam int SWD_MAG_W        = 24;
    localparam int SWD_EPS_W        = 23;
    localparam int SWD_CNT_CFG_W    = 7;
    localparam int SWD_LABEL_W      = 8;
    localparam int SWD_CFG_DW       = 23;
    localparam int SWD_CFG_AW       = 2;

    localparam logic [SWD_CFG_AW-1:0] CFG_EPSILON     = 2'd0;
    localparam logic [SWD_CFG_AW-1:0] CFG_MIN_POINTS  = 2'd1;
    localparam logic [SWD_CFG_AW-1:0] CFG_WINDOW_SIZE = 2'd2;

    localparam logic [SWD_EPS_W-1:0]     EPS_RESET   = 23'd400;
    localparam logic [SWD_CNT_CFG_W-1:0] MINP_RESET  = 7'd3;
    localparam logic [SWD_CNT_CFG_W-1:0] WSIZE_RESET = 7'd64;

    localparam logic signed [SWD_LABEL_W-1:0] SWD_NOISE_LABEL = -8'sd1;

    typedef enum logic [1:0] {
        PH_CORE,
        PH_NEAR,
        PH_ID
    } t_phase;

    // One command from the controller to the datapath.
    typedef struct packed {
        logic   valid;
        logic   first;
        logic   last;
        logic   load;
        logic   decide;
        logic   out_load;
        t_phase phase;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== design/swd_ctrl.sv =====
// Sequencer for the core, nearest-core and cluster-number sweeps.
`default_nettype none
module swd_ctrl import swd_pkg::*; #(
    parameter int DEPTH = SWD_WINDOW_DEPTH,
    localparam int AW = $clog2(DEPTH),
    localparam int SW = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_accept,
    input  wire logic [SW-1:0] i_fill,
    input  wire t_stat         i_stat,
    output logic               o_ready,
    output t_cmd               o_cmd,
    output logic [AW-1:0]      o_addr,
    output logic [AW-1:0]      o_idx
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_LOAD,
        ST_C_SWEEP,
        ST_C_DRAIN,
        ST_A_SWEEP,
        ST_A_DRAIN,
        ST_DECIDE,
        ST_B_LOAD,
        ST_B_SWEEP,
        ST_B_DRAIN,
        ST_DONE
    } t_state;

    t_state        r_state;
    logic          r_ready;
    t_cmd          r_cmd;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic          last_j;
    logic          last_i;

    assign last_j = (SW'(r_j) == i_fill - SW'(1));
    assign last_i = (SW'(r_i) == i_fill - SW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
            r_cmd   <= '0;
            r_addr  <= '0;
            r_idx   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_cmd <= '0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_accept) begin
                        r_ready <= 1'b0;
                        r_i     <= '0;
                        r_state <= ST_C_LOAD;
                    end
                end
                ST_C_LOAD, ST_B_LOAD: begin
                    r_cmd.load  <= 1'b1;
                    r_cmd.phase <= (r_state == ST_C_LOAD) ? PH_CORE : PH_ID;
                    r_addr      <= r_i;
                    r_idx       <= r_i;
                    r_j         <= '0;
                    r_state     <= (r_state == ST_C_LOAD) ? ST_C_SWEEP : ST_B_SWEEP;
                end
                ST_C_SWEEP, ST_B_SWEEP: begin
                    r_cmd.valid <= 1'b1;
                    r_cmd.first <= (r_j == '0);
                    r_cmd.last  <= last_j;
                    r_cmd.phase <= (r_state == ST_C_SWEEP) ? PH_CORE : PH_ID;
                    r_addr      <= r_j;
                    r_idx       <= r_i;
                    if (last_j) begin
                        if (last_i) begin
                            r_state <= (r_state == ST_C_SWEEP) ? ST_C_DRAIN : ST_B_DRAIN;
                        end else begin
                            r_i     <= r_i + AW'(1);
                            r_state <= (r_state == ST_C_SWEEP) ? ST_C_LOAD : ST_B_LOAD;
                        end
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                ST_C_DRAIN: begin
                    r_j     <= '0;
                    r_state <= ST_A_SWEEP;
                end
                ST_A_SWEEP: begin
                    r_cmd.valid <= 1'b1;
                    r_cmd.first <= (r_j == '0);
                    r_cmd.last  <= last_j;
                    r_cmd.phase <= PH_NEAR;
                    r_addr      <= r_j;
                    if (last_j) begin
                        r_state <= ST_A_DRAIN;
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                ST_A_DRAIN: begin
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    r_cmd.decide <= 1'b1;
                    r_i          <= '0;
                    r_state      <= ST_B_LOAD;
                end
                ST_B_DRAIN: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_stat.out_free) begin
                        r_cmd.out_load <= 1'b1;
                        r_ready        <= 1'b1;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready = r_ready;
    assign o_cmd   = r_cmd;
    assign o_addr  = r_addr;
    assign o_idx   = r_idx;

endmodule
`default_nettype wire

// ===== design/swd_dp.sv =====
// Window memory, core flags, configuration and the single comparator datapath.
`default_nettype none
module swd_dp import swd_pkg::*; #(
    parameter int DEPTH = SWD_WINDOW_DEPTH,
    localparam int AW = $clog2(DEPTH),
    localparam int SW = $clog2(DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [SWD_CFG_AW-1:0]         i_cfg_addr,
    input  wire logic [SWD_CFG_DW-1:0]         i_cfg_data,
    input  wire logic                          i_in_accept,
    input  wire logic signed [SWD_MAG_W-1:0]   i_mag,
    input  wire t_cmd                          i_cmd,
    input  wire logic [AW-1:0]                 i_addr,
    input  wire logic [AW-1:0]                 i_idx,
    input  wire logic                          i_out_ready,
    output logic [SW-1:0]                      o_fill,
    output t_stat                              o_stat,
    output logic                               o_out_valid,
    output logic signed [SWD_LABEL_W-1:0]      o_label
);

    localparam int DW = SWD_MAG_W + 1;

    logic signed [SWD_MAG_W-1:0] r_mem [DEPTH];
    logic                        r_core [DEPTH];

    logic [SWD_EPS_W-1:0]     r_eps;
    logic [SWD_CNT_CFG_W-1:0] r_minp;
    logic [SWD_CNT_CFG_W-1:0] r_ws;
    logic [SW-1:0]            r_fill;
    logic [AW-1:0]            r_oldest;
    logic signed [SWD_MAG_W-1:0] r_v;

    logic signed [SWD_MAG_W-1:0] r_rd;
    logic                        r_crd;
    t_cmd                        r_dcmd;
    logic [AW-1:0]               r_dj;
    logic [AW-1:0]               r_di;
    logic signed [SWD_MAG_W-1:0] r_xi;
    logic                        r_ci;

    logic [SW-1:0]               r_cnt;
    logic                        r_vcore, r_hp, r_hn;
    logic signed [SWD_MAG_W-1:0] r_p, r_nx, r_c;
    logic                        r_none;
    logic                        r_blk, r_dup;
    logic [SW-1:0]               r_id;
    logic                        r_oval;
    logic signed [SWD_LABEL_W-1:0] r_out;

    logic [SW-1:0]   size;
    logic            full;
    logic [AW-1:0]   waddr;
    logic signed [DW-1:0] eps_s, d, g, dp_d, dn_d;
    logic            in_eps, blk_hit, dup_hit;
    logic [SW-1:0]   n_cnt;
    logic            core_we, core_flag;
    logic            b_vcore, b_hp, b_hn, n_blk, n_dup, pin, nin;
    logic signed [SWD_MAG_W-1:0] b_p, b_nx;

    // Effective window size: zero counts as one, large values saturate.
    always_comb begin
        if (r_ws == '0) begin
            size = SW'(1);
        end else if (int'(r_ws) > DEPTH) begin
            size = SW'(DEPTH);
        end else begin
            size = SW'(r_ws);
        end
    end

    assign full  = (r_fill >= size);
    assign waddr = full ? r_oldest : r_fill[AW-1:0];

    assign eps_s   = signed'({2'b00, r_eps});
    assign d       = DW'(r_rd) - DW'(r_xi);
    assign g       = DW'(r_xi) - DW'(r_rd);
    assign in_eps  = (d <= eps_s) && (d >= -eps_s);
    assign blk_hit = r_crd && (g > 0) && (g <= eps_s);
    assign dup_hit = r_crd && (r_rd == r_xi) && (r_dj < r_di);

    assign n_cnt     = (r_dcmd.first ? SW'(0) : r_cnt) + SW'(in_eps);
    assign core_flag = (int'(n_cnt) >= int'(r_minp));
    assign core_we   = r_dcmd.valid && r_dcmd.last && (r_dcmd.phase == PH_CORE);

    assign b_vcore = r_dcmd.first ? 1'b0 : r_vcore;
    assign b_hp    = r_dcmd.first ? 1'b0 : r_hp;
    assign b_hn    = r_dcmd.first ? 1'b0 : r_hn;
    assign b_p     = r_p;
    assign b_nx    = r_nx;
    assign n_blk   = (r_dcmd.first ? 1'b0 : r_blk) | blk_hit;
    assign n_dup   = (r_dcmd.first ? 1'b0 : r_dup) | dup_hit;

    assign dp_d = DW'(r_v) - DW'(r_p);
    assign dn_d = DW'(r_nx) - DW'(r_v);
    assign pin  = r_hp && (dp_d <= eps_s);
    assign nin  = r_hn && (dn_d <= eps_s);

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_mem[waddr] <= i_mag;
        end
        r_rd <= r_mem[i_addr];
        if (core_we) begin
            r_core[r_di] <= core_flag;
        end
        r_crd <= r_core[i_addr];
    end

    always_ff @(posedge i_clk) begin
        r_dj <= i_addr;
        r_di <= i_idx;
        if (i_in_accept) begin
            r_v <= i_mag;
        end
        if (r_dcmd.load) begin
            r_xi <= r_rd;
            r_ci <= r_crd;
        end
        if (r_dcmd.valid && r_dcmd.phase == PH_CORE) begin
            r_cnt <= n_cnt;
        end
        if (r_dcmd.valid && r_dcmd.phase == PH_NEAR) begin
            r_vcore <= b_vcore | (r_crd && r_rd == r_v);
            r_hp    <= b_hp;
            r_hn    <= b_hn;
            if (r_crd && r_rd < r_v && (!b_hp || r_rd > b_p)) begin
                r_hp <= 1'b1;
                r_p  <= r_rd;
            end
            if (r_crd && r_rd > r_v && (!b_hn || r_rd < b_nx)) begin
                r_hn <= 1'b1;
                r_nx <= r_rd;
            end
        end
        if (r_dcmd.valid && r_dcmd.phase == PH_ID) begin
            r_blk <= n_blk;
            r_dup <= n_dup;
        end
        if (r_dcmd.decide) begin
            // Ties between the two neighboring cores go to the lower one.
            if (r_vcore) begin
                r_c <= r_v;
            end else if (pin && (!nin || dp_d <= dn_d)) begin
                r_c <= r_p;
            end else if (nin) begin
                r_c <= r_nx;
            end else begin
                r_c <= r_v;
            end
            r_none <= !r_vcore && !pin && !nin;
        end
        if (r_dcmd.out_load) begin
            r_out <= r_none ? SWD_NOISE_LABEL : SWD_LABEL_W'(r_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps    <= EPS_RESET;
            r_minp   <= MINP_RESET;
            r_ws     <= WSIZE_RESET;
            r_fill   <= '0;
            r_oldest <= '0;
            r_dcmd   <= '0;
            r_id     <= '0;
            r_oval   <= 1'b0;
        end else begin
            r_dcmd <= i_cmd;
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_EPSILON:    r_eps  <= i_cfg_data[SWD_EPS_W-1:0];
                    CFG_MIN_POINTS: r_minp <= i_cfg_data[SWD_CNT_CFG_W-1:0];
                    CFG_WINDOW_SIZE: begin
                        r_ws     <= i_cfg_data[SWD_CNT_CFG_W-1:0];
                        r_fill   <= '0;
                        r_oldest <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_in_accept) begin
                if (!full) begin
                    r_fill <= r_fill + SW'(1);
                end else if (SW'(r_oldest) == size - SW'(1)) begin
                    r_oldest <= '0;
                end else begin
                    r_oldest <= r_oldest + AW'(1);
                end
            end
            if (r_dcmd.decide) begin
                r_id <= '0;
            end else if (r_dcmd.valid && r_dcmd.last && r_dcmd.phase == PH_ID) begin
                // A distinct core with no core just below it opens a new cluster.
                if (r_ci && r_xi <= r_c && !n_blk && !n_dup) begin
                    r_id <= r_id + SW'(1);
                end
            end
            if (r_dcmd.out_load) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_fill          = r_fill;
    assign o_stat.out_free = !r_oval || i_out_ready;
    assign o_out_valid     = r_oval;
    assign o_label         = r_out;

endmodule
`default_nettype wire

// ===== design/sliding_window_dbscan_1d.sv =====
// Sliding-window 1-D DBSCAN labeler: top level.
// Usage:
//   The slave stream carries one event magnitude per request (signed, 1/8 VA).
//   Each request is appended to a window of the last window_size events, the
//   window is clustered, and one label for the newest event leaves on the
//   master stream: 1 upward by magnitude rank, or -1 for noise.
//   The configuration port writes epsilon, min_points and window_size by index;
//   writing window_size empties the window.
// Sequencing:
//   A new request is not taken until the label for the last one is done. One
//   comparator walks the window memory one entry per cycle: a full pass per
//   entry for the neighbor counts, one pass for the nearest cores, and a full
//   pass per entry again for the cluster numbering.
// Reset and stalls:
//   Reset empties the window and loads the register defaults. The result sits
//   in an output register, so a new request is taken while it waits; if the
//   receiver still stalls when the next label is done, the block holds it.
`default_nettype none
module sliding_window_dbscan_1d import swd_pkg::*; #(
    parameter int WINDOW_DEPTH = SWD_WINDOW_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [23:0]            s_axis_tdata,   // [23:0] magnitude
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] cluster_label
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [SWD_CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [SWD_CFG_DW-1:0]  i_cfg_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int SW = $clog2(WINDOW_DEPTH + 1);

    logic                          w_accept;
    logic                          w_ready;
    t_cmd                          w_cmd;
    t_stat                         w_stat;
    logic [AW-1:0]                 w_addr;
    logic [AW-1:0]                 w_idx;
    logic [SW-1:0]                 w_fill;
    logic signed [SWD_LABEL_W-1:0] w_label;

    assign s_axis_tready = w_ready;
    assign w_accept      = s_axis_tvalid && w_ready;
    assign m_axis_tdata  = w_label;

    swd_ctrl #(.DEPTH(WINDOW_DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_accept),
        .i_fill      (w_fill),
        .i_stat      (w_stat),
        .o_ready     (w_ready),
        .o_cmd       (w_cmd),
        .o_addr      (w_addr),
        .o_idx       (w_idx)
    );

    swd_dp #(.DEPTH(WINDOW_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_accept (w_accept),
        .i_mag       (signed'(s_axis_tdata)),
        .i_cmd       (w_cmd),
        .i_addr      (w_addr),
        .i_idx       (w_idx),
        .i_out_ready (m_axis_tready),
        .o_fill      (w_fill),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_label     (w_label)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("request taken while a label is still being computed");

    a_label_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata != 8'd0))
        else $error("label zero is never a valid cluster number");

    a_window_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (w_fill != '0))
        else $error("window empty after an event was stored");

endmodule
`default_nettype wire
